// ----- design/set_assoc_cache_lookup_fill_core_defines.svh -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_fill_core_defines
// assertion macros used by the cache core
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LOOKUP_FILL_CORE_DEFINES_SVH
`define SET_ASSOC_CACHE_LOOKUP_FILL_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SACL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define SACL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg
// shared constants and types of the set-associative cache
// ----------------------------------------------------------------------------
package sacl_pkg;
    localparam int NumSets    = 64;
    localparam int Ways       = 4;
    localparam int OffsetBits = 5;
    localparam int SetBits    = $clog2(NumSets);
    localparam int WayBits    = 2;
    localparam int TagBits    = 32 - OffsetBits - SetBits;
    localparam int Lines      = NumSets * Ways;
    localparam int LineBits   = $clog2(Lines);
    localparam int ChunkBits  = 2;
    localparam int StampBits  = 32;
    localparam logic [15:0] LfsrMask = 16'hB400;
    localparam logic [15:0] LfsrSeed = 16'h0001;

    typedef enum logic { OP_LOOKUP = 1'b0, OP_FILL = 1'b1 } op_t;
    typedef enum logic { POL_LRU = 1'b0, POL_RANDOM = 1'b1 } policy_t;

    typedef struct packed {
        logic                 we;
        logic [SetBits-1:0]   set_idx;
        logic [WayBits-1:0]   way;
        logic [TagBits-1:0]   tag;
        logic [StampBits-1:0] stamp;
        logic                 wr_tag;
    } meta_wr_t;
endpackage

// ----- design/set_assoc_cache_lookup_fill_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lookup_fill_core
// 4-way 64-set cache with 32-byte lines, lookup and chunked line fill
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// command   in         start & !busy    op, address, fill_chunk, fill_data
// result    out        done strobe      hit, read_byte, way_used
// config    in         apb write        replacement_policy
//
// lookup: set read, tag compare, data read
// fill: set read, then victim choice and write back
// busy is high from accept until the result strobe; start is ignored meanwhile
// reset clears valid bits, access clock and policy and seeds the lfsr; no clearing pass
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lookup_fill_core_defines.svh"

module set_assoc_cache_lookup_fill_core
    import sacl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [31:0] address,
    input  logic [1:0]  fill_chunk,
    input  logic [63:0] fill_data,
    output logic        done,
    output logic        hit,
    output logic [7:0]  read_byte,
    output logic [1:0]  way_used,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [1:0] { S_IDLE, S_EVAL, S_DATA } state_t;

    state_t                         state_reg;
    logic                           op_reg;
    logic [31:0]                    addr_reg;
    logic [1:0]                     chunk_reg;
    logic [63:0]                    data_reg;
    logic                           policy_reg;
    logic [StampBits-1:0]           clock_reg;
    logic [15:0]                    lfsr_reg;
    logic [WayBits-1:0]             fill_way_reg;
    logic [WayBits-1:0]             hit_way_reg;

    logic                           accept;
    logic [Ways-1:0]                rd_valid;
    logic [Ways-1:0][TagBits-1:0]   rd_tag;
    logic [Ways-1:0][StampBits-1:0] rd_stamp;
    meta_wr_t                       mwr;
    logic [63:0]                    drd;
    logic                           dwe;
    logic [LineBits+ChunkBits-1:0]  dwaddr;
    logic [LineBits+ChunkBits-1:0]  draddr;
    logic [SetBits-1:0]             cur_set;
    logic [TagBits-1:0]             cur_tag;
    logic                           any_hit;
    logic [WayBits-1:0]             hway;
    logic                           any_inv;
    logic [WayBits-1:0]             inv_way;
    logic [WayBits-1:0]             lru_way;
    logic [15:0]                    lfsr_next;
    logic [WayBits-1:0]             victim;
    logic [WayBits-1:0]             wway;
    logic                           cfg_wr;

    assign pready = 1'b1;
    assign prdata = {31'd0, policy_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign cur_set = addr_reg[OffsetBits +: SetBits];
    assign cur_tag = addr_reg[31 -: TagBits];

    sacl_meta_ram u_meta (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_set   (address[OffsetBits +: SetBits]),
        .rd_valid (rd_valid),
        .rd_tag   (rd_tag),
        .rd_stamp (rd_stamp),
        .wr       (mwr)
    );

    sacl_data_ram u_data (
        .clk     (clk),
        .rd_en   (state_reg == S_EVAL),
        .rd_addr (draddr),
        .rd_data (drd),
        .we      (dwe),
        .wr_addr (dwaddr),
        .wr_data (data_reg)
    );

    always_comb
    begin
        any_hit = 1'b0;
        hway    = '0;
        any_inv = 1'b0;
        inv_way = '0;
        lru_way = '0;
        for (int w = Ways - 1; w >= 0; w--)
        begin
            if (rd_valid[w] && rd_tag[w] == cur_tag)
            begin
                any_hit = 1'b1;
                hway    = WayBits'(w);
            end
            if (!rd_valid[w])
            begin
                any_inv = 1'b1;
                inv_way = WayBits'(w);
            end
        end
        for (int w = 1; w < Ways; w++)
        begin
            if (rd_stamp[w] < rd_stamp[lru_way])
            begin
                lru_way = WayBits'(w);
            end
        end
        lfsr_next = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? LfsrMask : 16'h0000);
        priority if (any_inv)
        begin
            victim = inv_way;
        end
        else if (policy_reg == POL_RANDOM)
        begin
            victim = lfsr_next[WayBits-1:0];
        end
        else
        begin
            victim = lru_way;
        end
        wway   = (chunk_reg == 2'd0) ? victim : fill_way_reg;
        draddr = {cur_set, hway, addr_reg[4:3]};
        dwaddr = {cur_set, wway, chunk_reg};
        dwe    = (state_reg == S_EVAL) && (op_reg == OP_FILL);

        mwr         = '0;
        mwr.set_idx = cur_set;
        mwr.tag     = cur_tag;
        mwr.stamp   = clock_reg;
        if (state_reg == S_EVAL)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                mwr.we  = any_hit;
                mwr.way = hway;
            end
            else
            begin
                mwr.we     = (chunk_reg == 2'd0);
                mwr.wr_tag = 1'b1;
                mwr.way    = victim;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            addr_reg  <= address;
            chunk_reg <= fill_chunk;
            data_reg  <= fill_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            policy_reg   <= 1'b0;
            clock_reg    <= '0;
            lfsr_reg     <= LfsrSeed;
            fill_way_reg <= '0;
            hit_way_reg  <= '0;
            done         <= 1'b0;
            hit          <= 1'b0;
            read_byte    <= '0;
            way_used     <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_wr)
            begin
                policy_reg <= pwdata[0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        hit_way_reg <= hway;
                        hit         <= any_hit;
                        if (any_hit)
                        begin
                            clock_reg <= clock_reg + 1'b1;
                        end
                        state_reg <= S_DATA;
                    end
                    else
                    begin
                        if (chunk_reg == 2'd0)
                        begin
                            fill_way_reg <= victim;
                            clock_reg    <= clock_reg + 1'b1;
                            if (!any_inv && policy_reg == POL_RANDOM)
                            begin
                                lfsr_reg <= lfsr_next;
                            end
                        end
                        done      <= 1'b1;
                        hit       <= 1'b0;
                        read_byte <= '0;
                        way_used  <= wway;
                        state_reg <= S_IDLE;
                    end
                end
                S_DATA:
                begin
                    done      <= 1'b1;
                    read_byte <= hit ? drd[{addr_reg[2:0], 3'b000} +: 8] : 8'd0;
                    way_used  <= hit ? hit_way_reg : 2'd0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SACL_ASSERT_NEXT(a_accept_busy, accept, busy)
    `SACL_ASSERT_IMP(a_done_idle, done, !busy)
    `SACL_ASSERT_IMP(a_fill_no_hit, done && $past(op_reg == OP_FILL && state_reg == S_EVAL), !hit)
    `SACL_ASSERT_NEXT(a_lookup_done, state_reg == S_DATA, done)
endmodule

// ----- design/sacl_meta_ram.sv -----
// ----------------------------------------------------------------------------
// sacl_meta_ram
// per-set tag and stamp memory plus valid bits, one read per cycle
// ----------------------------------------------------------------------------
module sacl_meta_ram
    import sacl_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [SetBits-1:0]             rd_set,
    output logic [Ways-1:0]                rd_valid,
    output logic [Ways-1:0][TagBits-1:0]   rd_tag,
    output logic [Ways-1:0][StampBits-1:0] rd_stamp,
    input  meta_wr_t                       wr
);
    logic [Ways-1:0][TagBits-1:0]   tag_mem   [NumSets];
    logic [Ways-1:0][StampBits-1:0] stamp_mem [NumSets];
    logic [Lines-1:0]               valid_reg;
    logic [SetBits-1:0]             set_reg;
    logic [LineBits-1:0]            wr_line;

    assign wr_line = LineBits'({wr.set_idx, wr.way});

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_tag   <= tag_mem[rd_set];
            rd_stamp <= stamp_mem[rd_set];
        end
        if (wr.we)
        begin
            stamp_mem[wr.set_idx][wr.way] <= wr.stamp;
            if (wr.wr_tag)
            begin
                tag_mem[wr.set_idx][wr.way] <= wr.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            set_reg   <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                set_reg <= rd_set;
            end
            if (wr.we && wr.wr_tag)
            begin
                valid_reg[wr_line] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < Ways; w++)
        begin
            rd_valid[w] = valid_reg[LineBits'({set_reg, WayBits'(w)})];
        end
    end
endmodule

// ----- design/sacl_data_ram.sv -----
// ----------------------------------------------------------------------------
// sacl_data_ram
// line data memory, one 64-bit chunk per entry
// ----------------------------------------------------------------------------
module sacl_data_ram
    import sacl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [LineBits+ChunkBits-1:0] rd_addr,
    output logic [63:0]                   rd_data,
    input  logic                          we,
    input  logic [LineBits+ChunkBits-1:0] wr_addr,
    input  logic [63:0]                   wr_data
);
    logic [63:0] mem [Lines*4];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the 4-way cache core against a predictor of lookups and line fills
// under lru and random replacement, with bursty command traffic and apb
// policy writes between phases
// ----------------------------------------------------------------------------
module testbench;
    import sacl_pkg::*;

    localparam logic [1:0] REG_POLICY = 2'd0;

    typedef struct {
        op_t         op;
        logic [31:0] addr;
        logic [1:0]  chunk;
        logic [63:0] data;
        logic        hit;
        logic [7:0]  rbyte;
        logic [1:0]  way;
    } cache_cmd_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic op;
    logic [31:0] address;
    logic [1:0] fill_chunk;
    logic [63:0] fill_data;
    logic done;
    logic hit;
    logic [7:0] read_byte;
    logic [1:0] way_used;
    logic psel;
    logic penable;
    logic pwrite;
    logic [1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    set_assoc_cache_lookup_fill_core dut (.*);

    // predictor state
    logic                 line_valid [Lines];
    logic [TagBits-1:0]   line_tag [Lines];
    logic [31:0]          line_stamp [Lines];
    logic [63:0]          line_bytes [Lines*4];
    logic                 chunk_written [Lines*4];
    logic [31:0]          access_clock;
    logic [15:0]          lfsr;
    logic [1:0]           fill_way;
    policy_t              policy;

    cache_cmd_t pending_cmds[$];
    cache_cmd_t expected_results[$];
    cache_cmd_t cur;
    int errors = 0;
    int n_lookups = 0;
    int n_hits = 0;
    int n_fills = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic taken = 1'b0;

    function automatic cache_cmd_t predict_cache(cache_cmd_t c);
        int base;
        int ln;
        int off;
        int best;
        logic [TagBits-1:0] tg;
        base = int'(c.addr[OffsetBits+SetBits-1:OffsetBits]) * Ways;
        tg = c.addr[31:OffsetBits+SetBits];
        c.hit = 1'b0;
        c.rbyte = 8'h00;
        c.way = 2'd0;
        if (c.op == OP_LOOKUP) begin
            for (int w = 0; w < Ways; w++) begin
                ln = base + w;
                if (line_valid[ln] && line_tag[ln] == tg) begin
                    // keep hits on chunks that have been filled
                    if (!chunk_written[ln*4 + int'(c.addr[4:3])])
                        c.addr[4:3] = 2'd0;
                    off = int'(c.addr[4:0]);
                    c.hit = 1'b1;
                    c.rbyte = line_bytes[ln*4 + off/8][(off%8)*8 +: 8];
                    c.way = w[1:0];
                    line_stamp[ln] = access_clock;
                    access_clock = access_clock + 1;
                    break;
                end
            end
            return c;
        end
        if (c.chunk == 2'd0) begin
            best = -1;
            for (int w = 0; w < Ways; w++)
                if (best < 0 && !line_valid[base+w])
                    best = w;
            if (best < 0 && policy == POL_RANDOM) begin
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ LfsrMask) : (lfsr >> 1);
                best = int'(lfsr[1:0]);
            end else if (best < 0) begin
                best = 0;
                for (int w = 1; w < Ways; w++)
                    if (line_stamp[base+w] < line_stamp[base+best])
                        best = w;
            end
            fill_way = best[1:0];
            ln = base + best;
            line_valid[ln] = 1'b1;
            line_tag[ln] = tg;
            line_stamp[ln] = access_clock;
            access_clock = access_clock + 1;
        end
        ln = base + int'(fill_way);
        line_bytes[ln*4 + int'(c.chunk)] = c.data;
        chunk_written[ln*4 + int'(c.chunk)] = 1'b1;
        c.way = fill_way;
        return c;
    endfunction

    task automatic queue_item(op_t o, logic [31:0] a, logic [1:0] ch, logic [63:0] d);
        cache_cmd_t c;
        c.op = o;
        c.addr = a;
        c.chunk = ch;
        c.data = d;
        pending_cmds.push_back(predict_cache(c));
    endtask

    task automatic fill_line(logic [31:0] a);
        for (int k = 0; k < 4; k++)
            queue_item(OP_FILL, a, k[1:0], {$urandom, $urandom});
    endtask

    function automatic logic [31:0] pool_addr();
        logic [20:0] tg;
        logic [5:0] st;
        case ($urandom_range(0, 9))
            0: tg = 21'h1FFFFF;
            1: tg = 21'($urandom);
            default: tg = 21'($urandom_range(0, 5));
        endcase
        case ($urandom_range(0, 3))
            0: st = 6'd0;
            1: st = 6'd63;
            default: st = 6'($urandom_range(1, 3));
        endcase
        return {tg, st, 5'($urandom_range(0, 31))};
    endfunction

    task automatic apb_write_policy(policy_t p);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_POLICY;
        pwdata <= {31'd0, p};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== p) begin
            $display("%0t policy readback: expected %0d actual %0d", $time, p, prdata[0]);
            errors++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        policy = p;
    endtask

    task automatic drain();
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int n;
        logic [31:0] a;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 9) < 7) begin
                a = pool_addr();
                if ($urandom_range(0, 2) == 0) begin
                    fill_line(a);
                    n += 4;
                end
                for (int k = $urandom_range(1, 4); k > 0; k--) begin
                    queue_item(OP_LOOKUP, ($urandom_range(0, 1) ? a : pool_addr()) ^
                               32'($urandom_range(0, 31)), 2'd0, {$urandom, $urandom});
                    n++;
                end
            end else begin
                a = $urandom_range(0, 1) ? $urandom : pool_addr();
                queue_item(op_t'($urandom_range(0, 1)), a, 2'($urandom_range(0, 3)),
                           {$urandom, $urandom});
                n++;
            end
        end
        drain();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    // driver: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken)) begin
            taken <= 1'b0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur = pending_cmds.pop_front();
                op <= cur.op;
                address <= cur.addr;
                fill_chunk <= cur.chunk;
                fill_data <= cur.data;
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy) begin
            expected_results.push_back(cur);
            taken <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cache_cmd_t e;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: hit %0b byte %h way %0d",
                         $time, hit, read_byte, way_used);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.op == OP_LOOKUP) n_lookups++;
                else n_fills++;
                if (e.hit) n_hits++;
                if (hit !== e.hit) begin
                    $display("%0t hit: expected %0b actual %0b", $time, e.hit, hit);
                    errors++;
                end
                if (read_byte !== e.rbyte) begin
                    $display("%0t read_byte: expected %h actual %h", $time, e.rbyte, read_byte);
                    errors++;
                end
                if (way_used !== e.way) begin
                    $display("%0t way_used: expected %0d actual %0d", $time, e.way, way_used);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < Lines; i++) line_valid[i] = 1'b0;
        for (int i = 0; i < Lines*4; i++) chunk_written[i] = 1'b0;
        access_clock = 32'd0;
        lfsr = LfsrSeed;
        fill_way = 2'd0;
        policy = POL_LRU;
        rst_n = 1'b0;
        start = 1'b0;
        op = 1'b0;
        address = 32'd0;
        fill_chunk = 2'd0;
        fill_data = 64'd0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 2'd0;
        pwdata = 32'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed
        apb_write_policy(POL_LRU);
        queue_item(OP_LOOKUP, 32'h0000_0000, 2'd0, 64'd0);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 2'd3, '1);
        queue_item(OP_FILL, 32'hFFFF_FFE0, 2'd0, '1);
        queue_item(OP_FILL, 32'hFFFF_FFE0, 2'd1, 64'd0);
        queue_item(OP_FILL, 32'hFFFF_FFE0, 2'd2, 64'h0123_4567_89AB_CDEF);
        queue_item(OP_FILL, 32'hFFFF_FFE0, 2'd3, 64'hFEDC_BA98_7654_3210);
        queue_item(OP_LOOKUP, 32'hFFFF_FFE0, 2'd0, 64'd0);
        queue_item(OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, 64'd0);
        // five allocations into one set force an lru eviction
        for (int t = 0; t < 5; t++)
            queue_item(OP_FILL, {21'(t), 6'd5, 5'd0}, 2'd0, 64'(t + 1));
        queue_item(OP_LOOKUP, {21'd0, 6'd5, 5'd3}, 2'd0, 64'd0);
        queue_item(OP_LOOKUP, {21'd4, 6'd5, 5'd7}, 2'd0, 64'd0);
        // later chunk with no allocation in its set
        queue_item(OP_FILL, {21'd9, 6'd40, 5'd0}, 2'd2, 64'hA5A5_5A5A_0F0F_F0F0);
        queue_item(OP_LOOKUP, {21'd2, 6'd5, 5'd1}, 2'd0, 64'd0);
        drain();
        random_phase(270);
        apb_write_policy(POL_RANDOM);
        for (int t = 0; t < 6; t++)
            queue_item(OP_FILL, {21'(t + 8), 6'd5, 5'd0}, 2'd0, 64'(t));
        random_phase(270);
        apb_write_policy(POL_LRU);
        random_phase(270);
        apb_write_policy(POL_RANDOM);
        random_phase(270);

        repeat (10) @(posedge clk);
        $display("checked %0d lookups (%0d hits) and %0d fill chunks over four policy phases",
                 n_lookups, n_hits, n_fills);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- set_assoc_cache_lookup_fill_core.f -----
+incdir+design
design/sacl_pkg.sv
design/sacl_meta_ram.sv
design/sacl_data_ram.sv
design/set_assoc_cache_lookup_fill_core.sv
dv/testbench.sv
